// File: src/radial_glare_overlay_core_defines.svh
// assertion macros for the radial glare overlay core
`ifndef RADIAL_GLARE_OVERLAY_CORE_DEFINES_SVH
`define RADIAL_GLARE_OVERLAY_CORE_DEFINES_SVH
`ifndef SYNTH
// checked on every clock edge outside reset
`define RGO_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("rgo assertion failed");
// checked on every clock edge, reset included
`define RGO_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
	else $error("rgo assertion failed");
`else
`define RGO_ASSERT(label, prop)
`define RGO_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: src/rgo_pkg.sv
`timescale 1ns / 1ps
package rgo_pkg;
	// field widths
	localparam int COORD_W    = 12;
	localparam int RAD_W      = 16;
	localparam int RAD_FRAC   = 4;
	localparam int CHAN_W     = 8;
	localparam int TRANS_W    = 12;
	localparam int GLARE_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// distance arithmetic
	localparam int SQ_W       = 2 * COORD_W;
	localparam int SUM_W      = SQ_W + 1;
	localparam int RADICAND_W = ((SUM_W + 2 * RAD_FRAC + 1) / 2) * 2;
	localparam int ROOT_W     = RADICAND_W / 2;
	localparam int REM_W      = ROOT_W + 2;

	// glare division: numerator 510*(outer-d)+band, divisor 2*band
	localparam int NUM_W      = RAD_W + 9;
	localparam int DEN_W      = RAD_W + 1;
	localparam int PROD_W     = TRANS_W + GLARE_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENCY = 3'd4;

	// glare region codes
	localparam logic [1:0] GL_ZERO = 2'd0;
	localparam logic [1:0] GL_FULL = 2'd1;
	localparam logic [1:0] GL_DIV  = 2'd2;

	localparam logic [GLARE_W-1:0] GLARE_MAX = '1;
	localparam logic [CHAN_W-1:0]  CHAN_MAX  = '1;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_row;
		logic [COORD_W-1:0] pixel_col;
		logic [CHAN_W-1:0]  in_blue;
		logic [CHAN_W-1:0]  in_green;
		logic [CHAN_W-1:0]  in_red;
	} pix_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_red;
	} pix_out_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

	typedef struct packed {
		logic [COORD_W-1:0] center_col;
		logic [COORD_W-1:0] center_row;
		logic [RAD_W-1:0]   inner_radius;
		logic [RAD_W-1:0]   outer_radius;
		logic [TRANS_W-1:0] transparency;
	} cfg_t;

	typedef struct packed {
		logic [ROOT_W-1:0] distance;
		rgb_t              pix;
	} dist_item_t;

	typedef struct packed {
		logic [GLARE_W-1:0] glare;
		rgb_t               pix;
	} glare_item_t;
endpackage

// File: src/rgo_dist.sv
`timescale 1ns / 1ps
`include "radial_glare_overlay_core_defines.svh"
module rgo_dist (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  rgo_pkg::cfg_t       cfg,
	input  logic                in_valid,
	input  rgo_pkg::pix_in_t    in_data,
	output logic                out_valid,
	output rgo_pkg::dist_item_t out_data
);
	import rgo_pkg::*;

	logic               vld_s1, vld_s2, vld_s3;
	logic [COORD_W-1:0] dx_s1, dy_s1;
	logic [SQ_W-1:0]    sqx_s2, sqy_s2;
	logic [RADICAND_W-1:0] rad_s3;
	rgb_t               pix_s1, pix_s2, pix_s3;
	logic [COORD_W-1:0] dx, dy;
	logic [SUM_W-1:0]   sum;

	// square root stages
	logic                  vld_sq  [ROOT_W];
	logic [REM_W-1:0]      rem_sq  [ROOT_W];
	logic [ROOT_W-1:0]     root_sq [ROOT_W];
	logic [RADICAND_W-1:0] rad_sq  [ROOT_W];
	rgb_t                  pix_sq  [ROOT_W];

	// absolute offsets from the center
	always_comb begin
		dx = (in_data.pixel_col >= cfg.center_col) ? in_data.pixel_col - cfg.center_col
			: cfg.center_col - in_data.pixel_col;
		dy = (in_data.pixel_row >= cfg.center_row) ? in_data.pixel_row - cfg.center_row
			: cfg.center_row - in_data.pixel_row;
		sum = SUM_W'(sqx_s2) + SUM_W'(sqy_s2);
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// offsets, squares, scaled sum of squares
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= dx;
			dy_s1  <= dy;
			pix_s1 <= '{blue: in_data.in_blue, green: in_data.in_green, red: in_data.in_red};
			sqx_s2 <= dx_s1 * dx_s1;
			sqy_s2 <= dy_s1 * dy_s1;
			pix_s2 <= pix_s1;
			rad_s3 <= RADICAND_W'(sum) << (2 * RAD_FRAC);
			pix_s3 <= pix_s2;
		end
	end

	// one root bit per stage
	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic [REM_W-1:0]      rem_in, cur, trial;
		logic [ROOT_W-1:0]     root_in;
		logic [RADICAND_W-1:0] rad_in;
		rgb_t                  pix_in;
		logic                  v_in, ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad_s3;
			assign pix_in  = pix_s3;
			assign v_in    = vld_s3;
		end else begin : g_next
			assign rem_in  = rem_sq[k-1];
			assign root_in = root_sq[k-1];
			assign rad_in  = rad_sq[k-1];
			assign pix_in  = pix_sq[k-1];
			assign v_in    = vld_sq[k-1];
		end

		assign cur   = {rem_in[REM_W-3:0], rad_in[RADICAND_W-1-2*k -: 2]};
		assign trial = {root_in, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq[k] <= 1'b0;
			end else if (adv) begin
				vld_sq[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sq[k]  <= ge ? cur - trial : cur;
				root_sq[k] <= {root_in[ROOT_W-2:0], ge};
				rad_sq[k]  <= rad_in;
				pix_sq[k]  <= pix_in;
			end
		end
	end

	assign out_valid         = vld_sq[ROOT_W-1];
	assign out_data.distance = root_sq[ROOT_W-1];
	assign out_data.pix      = pix_sq[ROOT_W-1];

	// remainder of a floor square root never exceeds twice the root
	`RGO_ASSERT(a_sqrt_rem, vld_sq[ROOT_W-1] |-> (rem_sq[ROOT_W-1] <= {1'b0, root_sq[ROOT_W-1], 1'b0}))
endmodule

// File: src/rgo_glare.sv
`timescale 1ns / 1ps
`include "radial_glare_overlay_core_defines.svh"
module rgo_glare (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  rgo_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	input  rgo_pkg::dist_item_t  in_data,
	output logic                 out_valid,
	output rgo_pkg::glare_item_t out_data
);
	import rgo_pkg::*;

	logic             vld_s1;
	logic [1:0]       mode_s1;
	logic [NUM_W-1:0] num_s1;
	logic [DEN_W-1:0] den_s1;
	rgb_t             pix_s1;

	logic             far, near;
	logic [RAD_W-1:0] band, diff;
	logic [NUM_W-1:0] num;
	logic [1:0]       mode;

	// divider stages
	logic               vld_dv  [GLARE_W];
	logic [NUM_W-1:0]   rem_dv  [GLARE_W];
	logic [DEN_W-1:0]   den_dv  [GLARE_W];
	logic [GLARE_W-1:0] quo_dv  [GLARE_W];
	logic [1:0]         mode_dv [GLARE_W];
	rgb_t               pix_dv  [GLARE_W];

	// classify the distance against the band
	always_comb begin
		far  = in_data.distance > ROOT_W'(cfg.outer_radius);
		near = in_data.distance < ROOT_W'(cfg.inner_radius);
		band = cfg.outer_radius - cfg.inner_radius;
		diff = cfg.outer_radius - in_data.distance[RAD_W-1:0];
		num  = (NUM_W'(diff) << 9) - (NUM_W'(diff) << 1) + NUM_W'(band);
		if (far || (!near && band == '0)) begin
			mode = GL_ZERO;
		end else if (near) begin
			mode = GL_FULL;
		end else begin
			mode = GL_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode;
			num_s1  <= num;
			den_s1  <= {band, 1'b0};
			pix_s1  <= in_data.pix;
		end
	end

	// restoring division, one quotient bit per stage, msb first
	for (genvar j = 0; j < GLARE_W; j++) begin : g_div
		logic [NUM_W-1:0]   rem_in, shifted;
		logic [DEN_W-1:0]   den_in;
		logic [GLARE_W-1:0] quo_in;
		logic [1:0]         mode_in;
		rgb_t               pix_in;
		logic               v_in, ge;

		if (j == 0) begin : g_first
			assign rem_in  = num_s1;
			assign den_in  = den_s1;
			assign quo_in  = '0;
			assign mode_in = mode_s1;
			assign pix_in  = pix_s1;
			assign v_in    = vld_s1;
		end else begin : g_next
			assign rem_in  = rem_dv[j-1];
			assign den_in  = den_dv[j-1];
			assign quo_in  = quo_dv[j-1];
			assign mode_in = mode_dv[j-1];
			assign pix_in  = pix_dv[j-1];
			assign v_in    = vld_dv[j-1];
		end

		assign shifted = NUM_W'(den_in) << (GLARE_W - 1 - j);
		assign ge      = rem_in >= shifted;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv[j] <= 1'b0;
			end else if (adv) begin
				vld_dv[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_dv[j]  <= ge ? rem_in - shifted : rem_in;
				den_dv[j]  <= den_in;
				quo_dv[j]  <= {quo_in[GLARE_W-2:0], ge};
				mode_dv[j] <= mode_in;
				pix_dv[j]  <= pix_in;
			end
		end
	end

	// pick the glare for the region
	always_comb begin
		case (mode_dv[GLARE_W-1])
			GL_FULL: out_data.glare = GLARE_MAX;
			GL_DIV:  out_data.glare = quo_dv[GLARE_W-1];
			default: out_data.glare = '0;
		endcase
		out_data.pix = pix_dv[GLARE_W-1];
	end

	assign out_valid = vld_dv[GLARE_W-1];

	// the divide path only sees a nonempty band
	`RGO_ASSERT(a_den_nonzero, (vld_s1 && mode_s1 == GL_DIV) |-> (den_s1 != '0))
	// quotient is complete: remainder below the divisor
	`RGO_ASSERT(a_div_rem, (vld_dv[GLARE_W-1] && mode_dv[GLARE_W-1] == GL_DIV) |-> (rem_dv[GLARE_W-1] < NUM_W'(den_dv[GLARE_W-1])))
endmodule

// File: src/rgo_blend.sv
`timescale 1ns / 1ps
module rgo_blend (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  rgo_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	input  rgo_pkg::glare_item_t in_data,
	output logic                 out_valid,
	output rgo_pkg::pix_out_t    out_data
);
	import rgo_pkg::*;

	localparam int ADD_W = PROD_W - 8 + 1;

	logic              vld_s1, vld_s2;
	logic [PROD_W-1:0] prod_s1;
	rgb_t              pix_s1;
	pix_out_t          res_s2;
	logic [ADD_W-1:0]  lift;

	function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] p,
			input logic [ADD_W-1:0] a);
		logic [ADD_W:0] s;
		s = (ADD_W+1)'(p) + (ADD_W+1)'(a);
		return (s > (ADD_W+1)'(CHAN_MAX)) ? CHAN_MAX : s[CHAN_W-1:0];
	endfunction

	// rounded glare contribution
	assign lift = ADD_W'(((PROD_W+1)'(prod_s1) + (PROD_W+1)'(128)) >> 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// weight, then add and saturate per channel
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1          <= PROD_W'(cfg.transparency) * PROD_W'(in_data.glare);
			pix_s1           <= in_data.pix;
			res_s2.out_blue  <= sat_add(pix_s1.blue, lift);
			res_s2.out_green <= sat_add(pix_s1.green, lift);
			res_s2.out_red   <= sat_add(pix_s1.red, lift);
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = res_s2;
endmodule

// File: src/radial_glare_overlay_core.sv
`timescale 1ns / 1ps
// channel | handshake              | payload
// pixel   | pix_valid / pix_ready  | pix_data  (row, col, blue, green, red)
// result  | res_valid / res_ready  | res_data  (blue, green, red)
// config  | cfg_wr_en              | cfg_addr, cfg_wdata
//
// one pixel per cycle while the output buffer has room; 20 distance/root stages, 9 glare/divide
// stages, 2 blend stages, 1 output buffer
// the pipeline moves as one while the two-entry output buffer has room
// reset clears valid bits, buffer pointers and configuration registers (all zero)
// a stalled result holds in the buffer; nothing is dropped or repeated
`include "radial_glare_overlay_core_defines.svh"
module radial_glare_overlay_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  rgo_pkg::pix_in_t                 pix_data,
	output logic                             res_valid,
	input  logic                             res_ready,
	output rgo_pkg::pix_out_t                res_data,
	input  logic                             cfg_wr_en,
	input  logic [rgo_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [rgo_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import rgo_pkg::*;

	cfg_t        cfg_q;
	logic        adv;
	logic        dist_valid, glare_valid, blend_valid;
	dist_item_t  dist_item;
	glare_item_t glare_item;
	pix_out_t    blend_item;
	pix_out_t    buf_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_CENTER_COL:   cfg_q.center_col   <= cfg_wdata[COORD_W-1:0];
				REG_CENTER_ROW:   cfg_q.center_row   <= cfg_wdata[COORD_W-1:0];
				REG_INNER_RADIUS: cfg_q.inner_radius <= cfg_wdata[RAD_W-1:0];
				REG_OUTER_RADIUS: cfg_q.outer_radius <= cfg_wdata[RAD_W-1:0];
				REG_TRANSPARENCY: cfg_q.transparency <= cfg_wdata[TRANS_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv       = cnt_q != 2'd2;
	assign pix_ready = adv;

	rgo_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg_q),
		.in_valid  (pix_valid),
		.in_data   (pix_data),
		.out_valid (dist_valid),
		.out_data  (dist_item)
	);

	rgo_glare u_glare (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg_q),
		.in_valid  (dist_valid),
		.in_data   (dist_item),
		.out_valid (glare_valid),
		.out_data  (glare_item)
	);

	rgo_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg_q),
		.in_valid  (glare_valid),
		.in_data   (glare_item),
		.out_valid (blend_valid),
		.out_data  (blend_item)
	);

	// two-entry output buffer
	assign push      = blend_valid && adv;
	assign pop       = res_valid && res_ready;
	assign res_valid = cnt_q != 2'd0;
	assign res_data  = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= blend_item;
		end
	end

	// buffer never overfills
	`RGO_ASSERT(a_buf_cnt, cnt_q <= 2'd2)
	// a full buffer halts the pipeline
	`RGO_ASSERT(a_full_stall, (cnt_q == 2'd2) |-> !push)
endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
	import rgo_pkg::*;

	localparam int LATENCY = 32;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_ready;
	pix_in_t pix_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	pix_out_t res_data;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// shadow configuration
	logic [COORD_W-1:0] sh_center_col, sh_center_row;
	logic [RAD_W-1:0] sh_inner, sh_outer;
	logic [TRANS_W-1:0] sh_trans;

	pix_out_t expected_pixels[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold = 1'b0;
	longint cycles = 0;

	radial_glare_overlay_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix_data(pix_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [CHAN_W-1:0] add_glare(input logic [CHAN_W-1:0] p,
			input logic [63:0] g);
		logic [63:0] s;
		s = p + ((sh_trans * g + 128) >> 8);
		return (s > 255) ? CHAN_MAX : s[CHAN_W-1:0];
	endfunction

	// expected blended pixel from shadow configuration
	function automatic pix_out_t glare_blend(input pix_in_t px);
		logic [63:0] dx, dy, distance, g, band;
		pix_out_t r;
		dx = 64'((px.pixel_col >= sh_center_col) ? px.pixel_col - sh_center_col
			: sh_center_col - px.pixel_col);
		dy = 64'((px.pixel_row >= sh_center_row) ? px.pixel_row - sh_center_row
			: sh_center_row - px.pixel_row);
		distance = int_sqrt((dx * dx + dy * dy) << (2 * RAD_FRAC));
		if (distance > sh_outer) begin
			g = 0;
		end else if (distance < sh_inner) begin
			g = 255;
		end else begin
			band = sh_outer - sh_inner;
			if (band == 0) g = 0;
			else g = (510 * (sh_outer - distance) + band) / (2 * band);
			if (g > 255) g = 255;
		end
		r.out_blue = add_glare(px.in_blue, g);
		r.out_green = add_glare(px.in_green, g);
		r.out_red = add_glare(px.in_red, g);
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_CENTER_COL: sh_center_col = val[COORD_W-1:0];
			REG_CENTER_ROW: sh_center_row = val[COORD_W-1:0];
			REG_INNER_RADIUS: sh_inner = val;
			REG_OUTER_RADIUS: sh_outer = val;
			REG_TRANSPARENCY: sh_trans = val[TRANS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int ccol, input int crow, input int inr, input int outr,
			input int tr);
		write_reg(REG_CENTER_COL, CFG_DATA_W'(ccol));
		write_reg(REG_CENTER_ROW, CFG_DATA_W'(crow));
		write_reg(REG_INNER_RADIUS, CFG_DATA_W'(inr));
		write_reg(REG_OUTER_RADIUS, CFG_DATA_W'(outr));
		write_reg(REG_TRANSPARENCY, CFG_DATA_W'(tr));
	endtask

	// offer one item and wait until it is taken; optional known result
	task automatic send_pixel(input pix_in_t px, input bit has_known, input pix_out_t known);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		expected_pixels.push_back(has_known ? known : glare_blend(px));
		pix_valid <= 1'b1;
		pix_data <= px;
		do @(posedge clk); while (!pix_ready);
	endtask

	task automatic drain;
		pix_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic pix_in_t rand_pixel(input int cc, input int cr, input int spread);
		pix_in_t px;
		int r, c;
		if ($urandom_range(9, 0) == 0) begin
			px.pixel_row = COORD_W'($urandom);
			px.pixel_col = COORD_W'($urandom);
		end else begin
			r = cr + $urandom_range(2 * spread, 0) - spread;
			c = cc + $urandom_range(2 * spread, 0) - spread;
			px.pixel_row = COORD_W'((r < 0) ? 0 : (r > 4095) ? 4095 : r);
			px.pixel_col = COORD_W'((c < 0) ? 0 : (c > 4095) ? 4095 : c);
		end
		px.in_blue = CHAN_W'($urandom);
		px.in_green = CHAN_W'($urandom);
		px.in_red = CHAN_W'($urandom);
		return px;
	endfunction

	// receiver: random stall plus one long hold-off
	always @(posedge clk) begin
		if (recv_hold) res_ready <= 1'b0;
		else res_ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item %h", res_data);
			end else begin
				if (res_data !== expected_pixels[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp b%0d g%0d r%0d got b%0d g%0d r%0d",
							expected_pixels[0].out_blue, expected_pixels[0].out_green,
							expected_pixels[0].out_red, res_data.out_blue,
							res_data.out_green, res_data.out_red);
				end
				void'(expected_pixels.pop_front());
			end
		end
	end

	typedef struct {
		int row, col, b, g, r;
		bit has_known;
		int kb, kg, kr;
	} stim_row_t;

	initial begin
		stim_row_t dir_rows[$];
		pix_in_t px;
		pix_out_t kn;
		int cc, cr, inr, outr, tr;
		sh_center_col = 0; sh_center_row = 0; sh_inner = 0; sh_outer = 0; sh_trans = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: transparency zero, pixel passes through
		dir_rows = '{
			'{0, 0, 0, 0, 0, 1, 0, 0, 0},
			'{4095, 4095, 255, 255, 255, 1, 255, 255, 255},
			'{1234, 2345, 12, 200, 77, 1, 12, 200, 77}};
		foreach (dir_rows[i]) begin
			px = '{COORD_W'(dir_rows[i].row), COORD_W'(dir_rows[i].col),
				CHAN_W'(dir_rows[i].b), CHAN_W'(dir_rows[i].g), CHAN_W'(dir_rows[i].r)};
			kn = '{CHAN_W'(dir_rows[i].kb), CHAN_W'(dir_rows[i].kg), CHAN_W'(dir_rows[i].kr)};
			send_pixel(px, dir_rows[i].has_known, kn);
		end
		drain();

		// full glare inside, transparency 1.0, saturation
		set_config(100, 100, 16'hFFFF, 16'hFFFF, 256);
		dir_rows = '{
			'{100, 100, 0, 0, 0, 1, 255, 255, 255},
			'{100, 100, 10, 0, 255, 1, 255, 255, 255},
			'{0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{4095, 4095, 1, 2, 3, 0, 0, 0, 0}};
		foreach (dir_rows[i]) begin
			px = '{COORD_W'(dir_rows[i].row), COORD_W'(dir_rows[i].col),
				CHAN_W'(dir_rows[i].b), CHAN_W'(dir_rows[i].g), CHAN_W'(dir_rows[i].r)};
			kn = '{CHAN_W'(dir_rows[i].kb), CHAN_W'(dir_rows[i].kg), CHAN_W'(dir_rows[i].kr)};
			send_pixel(px, dir_rows[i].has_known, kn);
		end
		drain();

		// empty band: distance equal to both radii gives zero glare
		set_config(0, 0, 48, 48, 4095);
		dir_rows = '{
			'{0, 3, 5, 6, 7, 1, 5, 6, 7},
			'{0, 2, 0, 0, 0, 1, 255, 255, 255},
			'{4, 0, 9, 9, 9, 1, 9, 9, 9}};
		foreach (dir_rows[i]) begin
			px = '{COORD_W'(dir_rows[i].row), COORD_W'(dir_rows[i].col),
				CHAN_W'(dir_rows[i].b), CHAN_W'(dir_rows[i].g), CHAN_W'(dir_rows[i].r)};
			kn = '{CHAN_W'(dir_rows[i].kb), CHAN_W'(dir_rows[i].kg), CHAN_W'(dir_rows[i].kr)};
			send_pixel(px, dir_rows[i].has_known, kn);
		end
		drain();

		// inner beyond outer, linear band, far corners
		set_config(4095, 4095, 800, 160, 128);
		dir_rows = '{
			'{4095, 4080, 0, 0, 0, 0, 0, 0, 0},
			'{4095, 4085, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, 100, 100, 100, 1, 100, 100, 100}};
		foreach (dir_rows[i]) begin
			px = '{COORD_W'(dir_rows[i].row), COORD_W'(dir_rows[i].col),
				CHAN_W'(dir_rows[i].b), CHAN_W'(dir_rows[i].g), CHAN_W'(dir_rows[i].r)};
			kn = '{CHAN_W'(dir_rows[i].kb), CHAN_W'(dir_rows[i].kg), CHAN_W'(dir_rows[i].kr)};
			send_pixel(px, dir_rows[i].has_known, kn);
		end
		drain();
		set_config(2000, 1000, 160, 1600, 200);
		for (int i = 0; i <= 110; i += 10) begin
			px = '{COORD_W'(1000), COORD_W'(2000 + i), CHAN_W'(i), CHAN_W'(255 - i),
				CHAN_W'(128)};
			send_pixel(px, 1'b0, kn);
		end
		drain();

		// random phases across idle profiles and settings
		for (int ph = 0; ph < 7; ph++) begin
			case (ph % 3)
				0: begin send_idle_pct = 32; recv_idle_pct = 82; end
				1: begin send_idle_pct = 82; recv_idle_pct = 32; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			cc = (ph == 5) ? 4095 : $urandom_range(4095, 0);
			cr = (ph == 6) ? 0 : $urandom_range(4095, 0);
			inr = (ph == 4) ? 0 : $urandom_range(2000, 0);
			outr = (ph == 4) ? 16'hFFFF : inr + $urandom_range(4000, 0);
			if (ph == 3) outr = inr;
			tr = (ph == 5) ? 4095 : (ph == 6) ? 0 : $urandom_range(4095, 0);
			set_config(cc, cr, inr, outr, tr);
			if (ph == 2) begin
				fork
					begin
						recv_hold = 1'b1;
						repeat (200) @(posedge clk);
						recv_hold = 1'b0;
					end
				join_none
			end
			repeat (250) send_pixel(rand_pixel(cc, cr, outr / 12 + 8), 1'b0, kn);
			drain();
		end

		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
